>>> rtl/core/lcdnw_pkg.sv
package lcdnw_pkg;

  localparam int unsigned MaxNibbles = 12;
  localparam int unsigned NumPlaces  = 5;
  localparam int unsigned MaxChars   = 6;
  localparam int unsigned IdxW       = $clog2(MaxNibbles);
  localparam int unsigned LenW       = $clog2(MaxNibbles + 1);
  localparam int unsigned PlaceW     = $clog2(NumPlaces);

  localparam logic [1:0] OpInit    = 2'd0;
  localparam logic [1:0] OpCommand = 2'd1;
  localparam logic [1:0] OpData    = 2'd2;
  localparam logic [1:0] OpPrint   = 2'd3;

  localparam logic [1:0] SettleShort = 2'd0;
  localparam logic [1:0] SettleLong  = 2'd1;
  localparam logic [1:0] SettleClear = 2'd2;

  localparam logic RsCommand = 1'b0;
  localparam logic RsData    = 1'b1;

  localparam logic [16:0] MaxNumber = 17'd99999;

  localparam logic [7:0] CursorLine1    = 8'h80;
  localparam logic [7:0] CursorLine2    = 8'hC0;
  localparam logic [7:0] AsciiZero      = 8'h30;
  localparam logic [7:0] AsciiE         = 8'h45;
  localparam logic [7:0] CmdFunctionSet = 8'h28;
  localparam logic [7:0] CmdDisplayOn   = 8'h0C;
  localparam logic [7:0] CmdEntryMode   = 8'h06;
  localparam logic [7:0] CmdClear       = 8'h01;
  localparam logic [3:0] WakeNibble     = 4'h3;
  localparam logic [3:0] FourBitNibble  = 4'h2;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic [7:0]                 byte_value;
    logic                       cursor_en;
    logic [7:0]                 cursor_byte;
    logic [3:0]                 digit_count;
    logic [16:0]                residue;
    logic [NumPlaces-1:0][3:0]  digits;
  } req_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic [1:0] settle;
  } nib_t;

  function automatic logic [16:0] place_value(int unsigned place);
    logic [16:0] pv;
    case (place)
      0:       pv = 17'd1;
      1:       pv = 17'd10;
      2:       pv = 17'd100;
      3:       pv = 17'd1000;
      default: pv = 17'd10000;
    endcase
    return pv;
  endfunction

  // Wake-up nibbles, then the four set-up commands high nibble first
  function automatic nib_t init_nibble(logic [IdxW-1:0] idx);
    nib_t n;
    n.rs     = RsCommand;
    n.settle = SettleShort;
    case (idx)
      4'd0, 4'd1, 4'd2: begin
        n.nibble = WakeNibble;
        n.settle = SettleLong;
      end
      4'd3: begin
        n.nibble = FourBitNibble;
        n.settle = SettleLong;
      end
      4'd4:  n.nibble = CmdFunctionSet[7:4];
      4'd5:  n.nibble = CmdFunctionSet[3:0];
      4'd6:  n.nibble = CmdDisplayOn[7:4];
      4'd7:  n.nibble = CmdDisplayOn[3:0];
      4'd8:  n.nibble = CmdEntryMode[7:4];
      4'd9:  n.nibble = CmdEntryMode[3:0];
      4'd10: n.nibble = CmdClear[7:4];
      4'd11: begin
        n.nibble = CmdClear[3:0];
        n.settle = SettleClear;
      end
      default: n.nibble = 4'h0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/char_lcd_nibble_writer.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  opcode, byte_value, row, column, number, digit_count
// out      output     out_valid_o/out_ready_i nibble, register_select, settle, last
//
// Requests enter a register, pass five decimal-place stages, then load the nibble sequencer.
// Unless the output stalls the sequencer sends one nibble per cycle; a list holds 2 to 12 nibbles;
// a print request with no cursor move and no digits produces nothing and takes no sequencer time.
// A request passes the input register, five place stages, list register and output register.
// rst_ni clears all valid flags asynchronously; no clearing pass.
// A stalled output holds its nibble; the stages behind it fill up and then drop in_ready_o.
module char_lcd_nibble_writer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  byte_value_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  column_i,
  input  logic [16:0] number_i,
  input  logic [3:0]  digit_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  nibble_o,
  output logic        register_select_o,
  output logic [1:0]  settle_o,
  output logic        last_o
);

  lcdnw_pkg::req_t  in_req;
  lcdnw_pkg::req_t  s0_q;
  logic             s0_valid_q;
  logic             s0_ready;
  logic             home;

  lcdnw_pkg::req_t  dig_req;
  logic             dig_valid;
  logic             dig_ready;
  logic             emit_ready;

  // Cursor command and number saturation
  always_comb begin
    home               = (row_i == 8'd0) || (column_i == 8'd0);
    in_req             = '0;
    in_req.opcode      = opcode_i;
    in_req.byte_value  = byte_value_i;
    in_req.digit_count = digit_count_i;
    in_req.cursor_en   = home || (row_i == 8'd1) || (row_i == 8'd2);
    if (home) begin
      in_req.cursor_byte = lcdnw_pkg::CursorLine1;
    end else if (row_i == 8'd1) begin
      in_req.cursor_byte = lcdnw_pkg::CursorLine1 + column_i - 8'd1;
    end else begin
      in_req.cursor_byte = lcdnw_pkg::CursorLine2 + column_i - 8'd1;
    end
    in_req.residue = (number_i > lcdnw_pkg::MaxNumber) ? lcdnw_pkg::MaxNumber : number_i;
  end

  assign s0_ready   = !s0_valid_q || dig_ready;
  assign in_ready_o = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_q <= in_req;
    end
  end

  lcdnw_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s0_valid_q),
    .in_ready_o  (dig_ready),
    .in_req_i    (s0_q),
    .out_valid_o (dig_valid),
    .out_ready_i (emit_ready),
    .out_req_o   (dig_req)
  );

  lcdnw_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (dig_valid),
    .in_ready_o        (emit_ready),
    .in_req_i          (dig_req),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .nibble_o          (nibble_o),
    .register_select_o (register_select_o),
    .settle_o          (settle_o),
    .last_o            (last_o)
  );

endmodule

>>> rtl/core/lcdnw_digits.sv
module lcdnw_digits (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lcdnw_pkg::req_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lcdnw_pkg::req_t   out_req_o
);

  localparam int unsigned N = lcdnw_pkg::NumPlaces;

  logic [N-1:0]     valid_q;
  lcdnw_pkg::req_t  req_q [N];
  logic [N:0]       stage_ready;

  assign stage_ready[N] = out_ready_i;
  assign in_ready_o     = stage_ready[0];
  assign out_valid_o    = valid_q[N-1];
  assign out_req_o      = req_q[N-1];

  // One decimal place per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Place = N - 1 - k;
    localparam logic [16:0] Pv    = lcdnw_pkg::place_value(Place);

    logic             src_valid;
    lcdnw_pkg::req_t  src_req;
    lcdnw_pkg::req_t  nxt_req;
    logic [8:0]       ge;
    logic [3:0]       digit;
    logic [16:0]      multiple;

    if (k == 0) begin : g_first
      assign src_valid = in_valid_i;
      assign src_req   = in_req_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_req   = req_q[k-1];
    end

    assign stage_ready[k] = !valid_q[k] || stage_ready[k+1];

    always_comb begin
      digit    = 4'd0;
      multiple = 17'd0;
      for (int m = 1; m <= 9; m++) begin
        ge[m-1] = src_req.residue >= 17'(m * Pv);
        if (ge[m-1]) begin
          digit    = 4'(m);
          multiple = 17'(m * Pv);
        end
      end
      nxt_req               = src_req;
      nxt_req.residue       = src_req.residue - multiple;
      nxt_req.digits[Place] = digit;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[k] && src_valid) begin
        req_q[k] <= nxt_req;
      end
    end
  end

  // Every place stripped: nothing may remain of a saturated number
  a_residue_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.residue == 17'd0)
    else $error("residue left after last decimal place");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.digits[N-1] <= 4'd9 && out_req_o.digits[0] <= 4'd9))
    else $error("digit outside decimal range");

endmodule

>>> rtl/core/lcdnw_emit.sv
module lcdnw_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lcdnw_pkg::req_t   in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        nibble_o,
  output logic              register_select_o,
  output logic [1:0]        settle_o,
  output logic              last_o
);

  localparam int unsigned M     = lcdnw_pkg::MaxNibbles;
  localparam int unsigned C     = lcdnw_pkg::MaxChars;
  localparam int unsigned IdxW  = lcdnw_pkg::IdxW;
  localparam int unsigned LenW  = lcdnw_pkg::LenW;
  localparam int unsigned PlW   = lcdnw_pkg::PlaceW;

  lcdnw_pkg::nib_t   plan [M];
  logic [LenW-1:0]   plan_len;
  logic [7:0]        chars [C];
  logic [7:0]        bytes [C];
  logic              byte_rs [C];
  logic [2:0]        nchars;
  logic [2:0]        nbytes;
  logic [PlW-1:0]    place;

  lcdnw_pkg::nib_t   ent_q [M];
  logic [LenW-1:0]   len_q;
  logic [IdxW-1:0]   idx_q;
  logic              ent_valid_q;

  lcdnw_pkg::nib_t   out_q;
  logic              out_last_q;
  logic              out_valid_q;

  logic              load_out;
  logic              at_end;
  logic              finishing;
  logic              take;
  logic [LenW-1:0]   idx_plus;

  // Build the nibble list for one request
  always_comb begin
    place  = '0;
    nchars = (in_req_i.digit_count > 4'd5) ? 3'd1 : in_req_i.digit_count[2:0];
    nbytes = nchars + {2'b00, in_req_i.cursor_en};
    for (int c = 0; c < C; c++) begin
      chars[c] = 8'h00;
      if (in_req_i.digit_count > 4'd5) begin
        if (c == 0) begin
          chars[c] = lcdnw_pkg::AsciiE;
        end
      end else if (4'(c) < in_req_i.digit_count) begin
        place    = PlW'(in_req_i.digit_count - 4'(c + 1));
        chars[c] = lcdnw_pkg::AsciiZero + {4'h0, in_req_i.digits[place]};
      end
    end
    for (int j = 0; j < C; j++) begin
      if (in_req_i.cursor_en) begin
        bytes[j]   = (j == 0) ? in_req_i.cursor_byte : chars[(j == 0) ? 0 : j - 1];
        byte_rs[j] = (j == 0) ? lcdnw_pkg::RsCommand : lcdnw_pkg::RsData;
      end else begin
        bytes[j]   = chars[j];
        byte_rs[j] = lcdnw_pkg::RsData;
      end
    end

    for (int s = 0; s < M; s++) begin
      plan[s] = '{nibble: 4'h0, rs: lcdnw_pkg::RsCommand, settle: lcdnw_pkg::SettleShort};
    end
    plan_len = '0;

    unique case (in_req_i.opcode) inside
      lcdnw_pkg::OpInit: begin
        for (int s = 0; s < M; s++) begin
          plan[s] = lcdnw_pkg::init_nibble(IdxW'(s));
        end
        plan_len = LenW'(M);
      end
      lcdnw_pkg::OpCommand, lcdnw_pkg::OpData: begin
        plan[0].nibble = in_req_i.byte_value[7:4];
        plan[1].nibble = in_req_i.byte_value[3:0];
        plan[0].rs     = (in_req_i.opcode == lcdnw_pkg::OpData);
        plan[1].rs     = (in_req_i.opcode == lcdnw_pkg::OpData);
        plan_len       = LenW'(2);
      end
      lcdnw_pkg::OpPrint: begin
        for (int j = 0; j < C; j++) begin
          plan[2*j].nibble   = bytes[j][7:4];
          plan[2*j+1].nibble = bytes[j][3:0];
          plan[2*j].rs       = byte_rs[j];
          plan[2*j+1].rs     = byte_rs[j];
        end
        plan_len = LenW'({nbytes, 1'b0});
      end
      default: plan_len = '0;
    endcase
  end

  assign idx_plus    = LenW'(idx_q) + LenW'(1);
  assign load_out    = ent_valid_q && (!out_valid_q || out_ready_i);
  assign at_end      = (idx_plus == len_q);
  assign finishing   = load_out && at_end;
  assign in_ready_o  = !ent_valid_q || finishing;
  assign take        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop requests that produce no transfer
      if (take) begin
        ent_valid_q <= (plan_len != '0);
        idx_q       <= '0;
      end else if (finishing) begin
        ent_valid_q <= 1'b0;
      end else if (load_out) begin
        idx_q <= IdxW'(idx_plus);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ent_q <= plan;
      len_q <= plan_len;
    end
    if (load_out) begin
      out_q      <= ent_q[idx_q];
      out_last_q <= at_end;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign nibble_o          = out_q.nibble;
  assign register_select_o = out_q.rs;
  assign settle_o          = out_q.settle;
  assign last_o            = out_last_q;

  a_index_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_valid_q |-> (len_q != '0 && LenW'(idx_q) < len_q))
    else $error("sequencer index beyond nibble list");

  a_clear_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && settle_o == lcdnw_pkg::SettleClear) |-> last_o)
    else $error("clear wait not on final nibble");

  a_data_short_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && register_select_o == lcdnw_pkg::RsData)
      |-> settle_o == lcdnw_pkg::SettleShort)
    else $error("data nibble with long hold");

  a_finish_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finishing && !take) |=> !ent_valid_q)
    else $error("sequencer still busy after final nibble");

endmodule

>>> sim/tb_char_lcd_nibble_writer.sv
module tb_char_lcd_nibble_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainGap   = 16;
  localparam int unsigned PhaseItems = 85;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  byte_value;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [16:0] number;
    logic [3:0]  digit_count;
  } lcd_req_t;

  typedef struct {
    logic [3:0] nibble;
    logic       rs;
    logic [1:0] settle;
    logic       last;
  } lcd_xfer_t;

  class nibble_scoreboard;
    lcd_xfer_t pending_xfers[$];
    lcd_xfer_t burst[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    function void add_nibble(logic [3:0] nib, logic rs, logic [1:0] settle);
      lcd_xfer_t x;
      x.nibble = nib;
      x.rs     = rs;
      x.settle = settle;
      x.last   = 1'b0;
      burst.push_back(x);
    endfunction

    function void add_byte(logic [7:0] b, logic rs, logic [1:0] settle_low);
      add_nibble(b[7:4], rs, lcdnw_pkg::SettleShort);
      add_nibble(b[3:0], rs, settle_low);
    endfunction

    // Expand one accepted request into the nibble transfers it must produce
    function void note_request(lcd_req_t r);
      logic [7:0]  cursor;
      logic [16:0] value;
      int unsigned scale;
      int unsigned digit;
      burst.delete();
      case (r.opcode)
        lcdnw_pkg::OpInit: begin
          repeat (3) add_nibble(lcdnw_pkg::WakeNibble, lcdnw_pkg::RsCommand,
                                lcdnw_pkg::SettleLong);
          add_nibble(lcdnw_pkg::FourBitNibble, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleLong);
          add_byte(lcdnw_pkg::CmdFunctionSet, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleShort);
          add_byte(lcdnw_pkg::CmdDisplayOn, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleShort);
          add_byte(lcdnw_pkg::CmdEntryMode, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleShort);
          add_byte(lcdnw_pkg::CmdClear, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleClear);
        end
        lcdnw_pkg::OpCommand:
          add_byte(r.byte_value, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleShort);
        lcdnw_pkg::OpData:
          add_byte(r.byte_value, lcdnw_pkg::RsData, lcdnw_pkg::SettleShort);
        default: begin
          if (r.row == 8'd0 || r.column == 8'd0) begin
            add_byte(lcdnw_pkg::CursorLine1, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleShort);
          end else if (r.row == 8'd1 || r.row == 8'd2) begin
            // 8-bit sum wraps like the display address does
            cursor = ((r.row == 8'd1) ? lcdnw_pkg::CursorLine1 : lcdnw_pkg::CursorLine2)
                     + r.column - 8'd1;
            add_byte(cursor, lcdnw_pkg::RsCommand, lcdnw_pkg::SettleShort);
          end
          value = (r.number > lcdnw_pkg::MaxNumber) ? lcdnw_pkg::MaxNumber : r.number;
          if (r.digit_count > 4'd5) begin
            add_byte(lcdnw_pkg::AsciiE, lcdnw_pkg::RsData, lcdnw_pkg::SettleShort);
          end else begin
            for (int i = r.digit_count; i > 0; i--) begin
              scale = 1;
              for (int k = 1; k < i; k++) scale = scale * 10;
              digit = (int'(value) / scale) % 10;
              add_byte(lcdnw_pkg::AsciiZero + 8'(digit), lcdnw_pkg::RsData,
                       lcdnw_pkg::SettleShort);
            end
          end
        end
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) pending_xfers.push_back(burst[i]);
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_xfer(logic [3:0] nib, logic rs, logic [1:0] settle, logic last);
      lcd_xfer_t want;
      if (pending_xfers.size() == 0) begin
        report($sformatf("unexpected transfer nibble=%h rs=%b settle=%0d last=%b",
                         nib, rs, settle, last));
      end else begin
        want = pending_xfers.pop_front();
        if (nib !== want.nibble)
          report($sformatf("nibble got %h want %h", nib, want.nibble));
        if (rs !== want.rs)
          report($sformatf("register_select got %b want %b", rs, want.rs));
        if (settle !== want.settle)
          report($sformatf("settle got %0d want %0d", settle, want.settle));
        if (last !== want.last)
          report($sformatf("last got %b want %b", last, want.last));
      end
    endtask

    function int unsigned outstanding();
      return pending_xfers.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i      = '0;
  logic [7:0]  byte_value_i  = '0;
  logic [7:0]  row_i         = '0;
  logic [7:0]  column_i      = '0;
  logic [16:0] number_i      = '0;
  logic [3:0]  digit_count_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [3:0]  nibble_o;
  logic        register_select_o;
  logic [1:0]  settle_o;
  logic        last_o;

  nibble_scoreboard board;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off       = 0;
  int unsigned cycle_count    = 0;

  char_lcd_nibble_writer u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .opcode_i,
    .byte_value_i,
    .row_i,
    .column_i,
    .number_i,
    .digit_count_i,
    .out_valid_o,
    .out_ready_i,
    .nibble_o,
    .register_select_o,
    .settle_o,
    .last_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold off for a counted stretch when asked, else stall at random
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready_i = 1'b0;
        hold_off--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_xfer(nibble_o, register_select_o, settle_o, last_o);
  end

  function automatic lcd_req_t make_req(logic [1:0] op, logic [7:0] b, logic [7:0] r,
                                        logic [7:0] c, logic [16:0] n, logic [3:0] d);
    lcd_req_t q;
    q.opcode      = op;
    q.byte_value  = b;
    q.row         = r;
    q.column      = c;
    q.number      = n;
    q.digit_count = d;
    return q;
  endfunction

  function automatic lcd_req_t random_req();
    lcd_req_t q;
    q.opcode      = 2'($urandom_range(3));
    q.byte_value  = 8'($urandom);
    q.row         = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    q.column      = ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255));
    q.number      = ($urandom_range(3) == 0) ? 17'($urandom_range(131071))
                                             : 17'($urandom_range(99999));
    q.digit_count = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
    return q;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(lcd_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    opcode_i      = r.opcode;
    byte_value_i  = r.byte_value;
    row_i         = r.row;
    column_i      = r.column;
    number_i      = r.number;
    digit_count_i = r.digit_count;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
    repeat (DrainGap) @(negedge clk_i);
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(make_req(lcdnw_pkg::OpInit, 8'h00, 8'h00, 8'h00, 17'd0, 4'd0));
    send_request(make_req(lcdnw_pkg::OpCommand, 8'h00, 8'hFF, 8'hFF, 17'h1FFFF, 4'hF));
    send_request(make_req(lcdnw_pkg::OpCommand, 8'hFF, 8'h00, 8'h00, 17'd0, 4'd0));
    send_request(make_req(lcdnw_pkg::OpData, 8'h00, 8'h01, 8'h01, 17'd5, 4'd2));
    send_request(make_req(lcdnw_pkg::OpData, 8'hFF, 8'h02, 8'h02, 17'd7, 4'd3));
    send_request(make_req(lcdnw_pkg::OpData, 8'hA5, 8'h00, 8'h00, 17'd0, 4'd0));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd0, 8'd5, 17'd42, 4'd2));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'hFF, 8'd5, 8'd0, 17'd42, 4'd2));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd1, 8'd1, 17'd9, 4'd1));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd1, 8'd255, 17'd123, 4'd3));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd2, 8'd1, 17'd0, 4'd5));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd2, 8'd64, 17'd99999, 4'd5));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd2, 8'd255, 17'h1FFFF, 4'd5));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd3, 8'd7, 17'd55, 4'd0));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd255, 8'd255, 17'd100000, 4'd3));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd1, 8'd16, 17'd12345, 4'd1));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd1, 8'd40, 17'd12345, 4'd0));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd9, 8'd3, 17'd777, 4'd6));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd2, 8'd8, 17'd777, 4'd15));
    send_request(make_req(lcdnw_pkg::OpPrint, 8'h00, 8'd0, 8'd0, 17'd65536, 4'd4));
    send_request(make_req(lcdnw_pkg::OpInit, 8'hFF, 8'hFF, 8'hFF, 17'h1FFFF, 4'hF));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      repeat (PhaseItems) send_request(random_req());
      if (phase == 1) begin
        // Block the output long enough for the pipeline to back up
        send_idle_pct = 0;
        hold_off = 300;
        repeat (16) send_request(random_req());
        wait_drained();
      end
    end

    wait_drained();
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_digits.sv
rtl/core/lcdnw_emit.sv
rtl/core/char_lcd_nibble_writer.sv
sim/tb_char_lcd_nibble_writer.sv
